FILE: hdl/nnis_pkg.sv
// Package for the nearest-neighbor image scaler.
// Shared widths, constants and enum types. No dependencies.
package nnis_pkg;

    localparam int SCALE_W     = 8;
    localparam int DIM_W       = 10;
    localparam int PIX_W       = 32;
    localparam int COORD_W     = 10;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 10;
    localparam int S_TDATA_W   = 32;
    localparam int M_TDATA_W   = 56;
    localparam int PAD_W       = M_TDATA_W - PIX_W - 2 * COORD_W;

    // step divider: 200 div 2s, one quotient bit a cycle
    localparam int DIV_W       = SCALE_W;
    localparam int DVS_W       = SCALE_W + 1;
    localparam int REM_W       = DVS_W;
    localparam int DIV_CNT_W   = 3;
    localparam int STEP_W      = 7;

    // frame size: dim * s div 100 as (dim * s * RECIP_100) >> RECIP_SHIFT, exact below 2**18
    localparam int PROD_W      = DIM_W + SCALE_W;
    localparam int RECIP_W     = 19;
    localparam int RECIP_SHIFT = 25;
    localparam int RECIP_100   = 335545;

    localparam int UNITY_PCT   = 100;
    localparam int TWICE_UNITY = 200;
    localparam int SCALE_RST   = 100;
    localparam int DIM_RST     = 512;
    localparam int DIM_LIMIT   = 1023;
    localparam int SCALE_LIMIT = 255;

    localparam int DEF_MAX_WIDTH  = 512;
    localparam int DEF_MAX_HEIGHT = 512;
    localparam int DEF_MAX_SCALE  = 200;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCALE  = 2'd0,
        CFG_WIDTH  = 2'd1,
        CFG_HEIGHT = 2'd2,
        CFG_NONE   = 2'd3
    } t_cfg_idx;

    typedef enum logic {
        ACT_LOAD  = 1'b0,
        ACT_FETCH = 1'b1
    } t_action;

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } t_state;

endpackage

FILE: hdl/nearest_neighbor_image_scaler.sv
// Nearest-neighbor image scaler, top level.
// Uses nnis_pkg. Holds the image memory, the divider sequencer and the fetch path.
//
// A load item (tuser = 0) writes tdata as the next source pixel in raster order.
// A fetch item (tuser = 1) returns the next pixel of the scaled frame in raster order:
// in the accept cycle the source column and row are advanced by a frame-constant step,
// then the image memory is read synchronously; a stalled output holds off further
// items once its one-item buffer is full. A fetch on an empty scaled frame returns
// nothing. After reset and after each write of register 0, 1 or 2 a restoring divider
// works out the column/row step, and no item is accepted during that pass; the scaled
// frame size is taken at the end of the pass from a reciprocal multiply of dimension
// times scale.
module nearest_neighbor_image_scaler
    import nnis_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int MAX_SCALE  = DEF_MAX_SCALE
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,   // [31:0] pixel_in
    input  logic                  s_axis_tuser,   // [0] action
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [M_TDATA_W-1:0]  m_axis_tdata,   // [31:0] pixel_out, [41:32] dest_x,
                                                  // [51:42] dest_y, [55:52] zero
    output logic                  m_axis_tlast    // last_pixel
);

    localparam int WIDTH_CAP  = (MAX_WIDTH > DIM_LIMIT) ? DIM_LIMIT : MAX_WIDTH;
    localparam int HEIGHT_CAP = (MAX_HEIGHT > DIM_LIMIT) ? DIM_LIMIT : MAX_HEIGHT;
    localparam int SCALE_CAP  = (MAX_SCALE > SCALE_LIMIT) ? SCALE_LIMIT : MAX_SCALE;
    localparam int DW_MAX     = WIDTH_CAP * SCALE_CAP / UNITY_PCT;
    localparam int DH_MAX     = HEIGHT_CAP * SCALE_CAP / UNITY_PCT;
    localparam int CNT_W      = $clog2(((DW_MAX > DH_MAX) ? DW_MAX : DH_MAX) + 1);
    localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int W_RST      = (DIM_RST > MAX_WIDTH) ? MAX_WIDTH : DIM_RST;
    localparam int H_RST      = (DIM_RST > MAX_HEIGHT) ? MAX_HEIGHT : DIM_RST;
    localparam int QW         = DIM_W + 1;
    localparam int LIN_W      = 2 * DIM_W + 1;
    localparam int CMP_W      = (ADDR_W + 1 > 2 * DIM_W) ? ADDR_W + 1 : 2 * DIM_W;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v, input int cap);
        logic [DIM_W-1:0] res;
        res = v;
        if (v == '0) begin
            res = DIM_W'(1);
        end else if (int'(v) > cap) begin
            res = DIM_W'(cap);
        end
        return res;
    endfunction

    logic [PIX_W-1:0] mem [DEPTH];

    // configuration
    logic [SCALE_W-1:0]   r_scale;
    logic [DIM_W-1:0]     r_width, r_height;
    logic [2*DIM_W-1:0]   r_area;
    logic [PROD_W-1:0]    r_wsc, r_hsc;
    // divider sequencer
    logic                 r_busy, r_init;
    logic [DIV_W-1:0]     r_dvd;
    logic [REM_W-1:0]     r_rem;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [STEP_W-1:0]    r_q_step;
    logic [REM_W-1:0]     r_r_step;
    logic [CNT_W-1:0]     r_dw, r_dh;
    // pointers and stepping
    logic [ADDR_W-1:0]    r_lp;
    logic [CNT_W-1:0]     r_col, r_row;
    logic [QW-1:0]        r_qx, r_qy;
    logic [REM_W-1:0]     r_rx, r_ry;
    // fetch path
    t_state               r_state, n_state;
    logic [DIM_W-1:0]     r_sx, r_sy;
    logic [COORD_W-1:0]   r_dx, r_dy;
    logic                 r_last;
    logic [PIX_W-1:0]     r_rd_data;
    logic                 r_pend;
    logic                 r_out_valid;
    logic [PIX_W-1:0]     r_out_pix;
    logic [COORD_W-1:0]   r_out_dx, r_out_dy;
    logic                 r_out_last;

    logic                 w_in_slot, w_rd_en;
    logic                 w_out_free, w_move;
    logic                 w_load_go, w_fetch_go, w_frame_ok;
    logic                 w_scale_ok, w_div_last, w_fin;
    logic [DVS_W-1:0]     w_divisor;
    logic [DIV_W-1:0]     w_quo_nx;
    logic [REM_W:0]       w_trial, w_diff;
    logic                 w_qbit;
    logic [REM_W-1:0]     w_rem_nx;
    logic [PROD_W+RECIP_W-1:0] w_dw_prod, w_dh_prod;
    logic [REM_W:0]       w_s2;
    logic [REM_W:0]       w_sum_x, w_sum_y, w_sub_x, w_sub_y;
    logic                 w_wrap_x, w_wrap_y;
    logic [REM_W-1:0]     w_rx_nx, w_ry_nx;
    logic [QW-1:0]        w_qx_nx, w_qy_nx;
    logic                 w_col_last, w_row_last;
    logic [2*DIM_W-1:0]   w_prod;
    logic [LIN_W-1:0]     w_lin;
    logic [ADDR_W-1:0]    w_addr;
    logic [ADDR_W:0]      w_lp_inc;

    // ---------------- handshake ----------------
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_move        = r_pend && w_out_free;
    assign s_axis_tready = w_in_slot && !r_busy && (!r_pend || w_out_free);
    assign w_frame_ok    = (r_dw != '0) && (r_dh != '0);
    assign w_load_go     = s_axis_tvalid && s_axis_tready && (s_axis_tuser == ACT_LOAD);
    assign w_fetch_go    = s_axis_tvalid && s_axis_tready && (s_axis_tuser == ACT_FETCH)
                           && w_frame_ok;

    // ---------------- configuration ----------------
    assign w_scale_ok = (i_cfg_data[SCALE_W-1:0] != '0)
                        && (int'(i_cfg_data[SCALE_W-1:0]) <= MAX_SCALE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale  <= SCALE_W'(SCALE_RST);
            r_width  <= DIM_W'(W_RST);
            r_height <= DIM_W'(H_RST);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_SCALE: begin
                    if (w_scale_ok) begin
                        r_scale <= i_cfg_data[SCALE_W-1:0];
                    end
                end
                CFG_WIDTH:  r_width  <= clamp_dim(i_cfg_data, WIDTH_CAP);
                CFG_HEIGHT: r_height <= clamp_dim(i_cfg_data, HEIGHT_CAP);
                CFG_NONE: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_area <= r_width * r_height;
        r_wsc  <= r_width * r_scale;
        r_hsc  <= r_height * r_scale;
    end

    // ---------------- divider: step = 200 / 2s; frame = dim * s / 100 by reciprocal -------
    assign w_divisor = {r_scale, 1'b0};
    assign w_dw_prod = r_wsc * RECIP_W'(RECIP_100);
    assign w_dh_prod = r_hsc * RECIP_W'(RECIP_100);

    assign w_trial    = {r_rem, r_dvd[DIV_W-1]};
    assign w_qbit     = (w_trial >= {1'b0, w_divisor});
    assign w_diff     = w_trial - {1'b0, w_divisor};
    assign w_rem_nx   = w_qbit ? w_diff[REM_W-1:0] : w_trial[REM_W-1:0];
    assign w_quo_nx   = {r_dvd[DIV_W-2:0], w_qbit};
    assign w_div_last = (r_cnt == DIV_CNT_W'(DIV_W - 1));
    assign w_fin      = r_busy && !r_init && w_div_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_init <= 1'b1;
            r_cnt  <= '0;
        end else if (i_cfg_we && (i_cfg_idx != CFG_NONE)) begin
            r_busy <= 1'b1;
            r_init <= 1'b1;
        end else if (r_busy) begin
            if (r_init) begin
                r_dvd  <= DIV_W'(TWICE_UNITY);
                r_rem  <= '0;
                r_cnt  <= '0;
                r_init <= 1'b0;
            end else begin
                r_dvd <= w_quo_nx;
                r_rem <= w_rem_nx;
                r_cnt <= r_cnt + DIV_CNT_W'(1);
                if (w_div_last) begin
                    r_q_step <= STEP_W'(w_quo_nx);
                    r_r_step <= w_rem_nx;
                    r_dw     <= CNT_W'(w_dw_prod[PROD_W+RECIP_W-1:RECIP_SHIFT]);
                    r_dh     <= CNT_W'(w_dh_prod[PROD_W+RECIP_W-1:RECIP_SHIFT]);
                    r_busy   <= 1'b0;
                end
            end
        end
    end

    // ---------------- load pointer ----------------
    assign w_lp_inc = {1'b0, r_lp} + (ADDR_W + 1)'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lp <= '0;
        end else if (i_cfg_we && ((i_cfg_idx == CFG_WIDTH) || (i_cfg_idx == CFG_HEIGHT))) begin
            r_lp <= '0;
        end else if (w_load_go) begin
            if (CMP_W'(w_lp_inc) >= CMP_W'(r_area)) begin
                r_lp <= '0;
            end else begin
                r_lp <= w_lp_inc[ADDR_W-1:0];
            end
        end
    end

    // ---------------- source stepping: q = (200*d + s) div 2s, kept incrementally ----------
    assign w_s2       = {1'b0, r_scale, 1'b0};
    assign w_sum_x    = {1'b0, r_rx} + {1'b0, r_r_step};
    assign w_sum_y    = {1'b0, r_ry} + {1'b0, r_r_step};
    assign w_wrap_x   = (w_sum_x >= w_s2);
    assign w_wrap_y   = (w_sum_y >= w_s2);
    assign w_sub_x    = w_sum_x - w_s2;
    assign w_sub_y    = w_sum_y - w_s2;
    assign w_rx_nx    = w_wrap_x ? w_sub_x[REM_W-1:0] : w_sum_x[REM_W-1:0];
    assign w_ry_nx    = w_wrap_y ? w_sub_y[REM_W-1:0] : w_sum_y[REM_W-1:0];
    assign w_qx_nx    = r_qx + QW'(r_q_step) + QW'(w_wrap_x);
    assign w_qy_nx    = r_qy + QW'(r_q_step) + QW'(w_wrap_y);
    assign w_col_last = (r_col == r_dw - CNT_W'(1));
    assign w_row_last = (r_row == r_dh - CNT_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (w_fin) begin
            r_col <= '0;
            r_row <= '0;
            r_qx  <= '0;
            r_qy  <= '0;
            r_rx  <= REM_W'(r_scale);
            r_ry  <= REM_W'(r_scale);
        end else if (w_fetch_go) begin
            if (w_col_last) begin
                r_col <= '0;
                r_qx  <= '0;
                r_rx  <= REM_W'(r_scale);
                if (w_row_last) begin
                    r_row <= '0;
                    r_qy  <= '0;
                    r_ry  <= REM_W'(r_scale);
                end else begin
                    r_row <= r_row + CNT_W'(1);
                    r_qy  <= w_qy_nx;
                    r_ry  <= w_ry_nx;
                end
            end else begin
                r_col <= r_col + CNT_W'(1);
                r_qx  <= w_qx_nx;
                r_rx  <= w_rx_nx;
            end
        end
    end

    // clamped source position and tags of the accepted fetch
    always_ff @(posedge i_clk) begin
        if (w_fetch_go) begin
            r_sx   <= (r_qx >= {1'b0, r_width}) ? r_width - DIM_W'(1) : r_qx[DIM_W-1:0];
            r_sy   <= (r_qy >= {1'b0, r_height}) ? r_height - DIM_W'(1) : r_qy[DIM_W-1:0];
            r_dx   <= COORD_W'(r_col);
            r_dy   <= COORD_W'(r_row);
            r_last <= w_col_last && w_row_last;
        end
    end

    // ---------------- fetch sequencer ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_fetch_go) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        w_in_slot = 1'b0;
        w_rd_en   = 1'b0;
        unique case (r_state)
            ST_IDLE: w_in_slot = 1'b1;
            ST_READ: w_rd_en   = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ---------------- image memory ----------------
    assign w_prod = r_sy * r_width;
    assign w_lin  = {1'b0, w_prod} + LIN_W'(r_sx);
    assign w_addr = ADDR_W'(w_lin);

    always_ff @(posedge i_clk) begin
        if (w_load_go) begin
            mem[r_lp] <= s_axis_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rd_data <= mem[w_addr];
        end
    end

    // ---------------- output buffer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_rd_en) begin
                r_pend <= 1'b1;
            end else if (w_move) begin
                r_pend <= 1'b0;
            end
            if (w_move) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_move) begin
            r_out_pix  <= r_rd_data;
            r_out_dx   <= r_dx;
            r_out_dy   <= r_dy;
            r_out_last <= r_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, r_out_dy, r_out_dx, r_out_pix};
    assign m_axis_tlast  = r_out_last;

endmodule

FILE: hdl/nnis_checker.sv
// Port-level checks for the nearest-neighbor image scaler.
// Uses nnis_pkg; bound to nearest_neighbor_image_scaler below.
module nnis_checker
    import nnis_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_cfg_we,
    input logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [M_TDATA_W-1:0]  m_axis_tdata,
    input logic                  m_axis_tlast
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output item dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output item changed while stalled");

    a_cfg_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we && (i_cfg_idx != CFG_NONE) |=> !s_axis_tready)
        else $error("item taken before frame setup was recomputed");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && !s_axis_tready)
        else $error("block not quiet after reset");

endmodule

bind nearest_neighbor_image_scaler nnis_checker u_nnis_checker (.*);

FILE: test/testbench.sv
`timescale 1ns / 1ps
// Testbench for nearest_neighbor_image_scaler: loads source images, fetches scaled
// frames and checks every returned pixel against an in-bench nearest-neighbor predictor.
// Depends on nnis_pkg and the scaler RTL only.
module testbench;
    import nnis_pkg::*;

    localparam int     MAX_W         = DEF_MAX_WIDTH;
    localparam int     MAX_H         = DEF_MAX_HEIGHT;
    localparam int     MAX_SC        = DEF_MAX_SCALE;
    localparam int     STORE_DEPTH   = MAX_W * MAX_H;
    localparam int     SETTLE_CYCLES = 16;   // covers the divider pass
    localparam int     HOLD_CYCLES   = 400;
    localparam int     TAIL_CYCLES   = 16;
    localparam int     RANDOM_ITEMS  = 660;
    localparam longint CYCLE_LIMIT   = 500000;

    typedef struct packed {
        logic [PIX_W-1:0]   pixel;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               last;
    } t_scaled_pixel;

    class scaled_frame_board;
        int unsigned       scale, width, height;
        int unsigned       load_ptr, col, row;
        bit [PIX_W-1:0]    src_image [int unsigned];
        t_scaled_pixel     pending_pixels [$];
        int                errors, loads, fetches, empty_fetches, checked;

        function new();
            scale    = SCALE_RST;
            width    = DIM_RST;
            height   = DIM_RST;
            load_ptr = 0;
            col      = 0;
            row      = 0;
        endfunction

        function int unsigned fit_dim(int unsigned v, int unsigned lim);
            if (v == 0) return 1;
            return (v > lim) ? lim : v;
        endfunction

        // round-half-up of d*100/scale, clamped to the last source line
        function int unsigned nearest_src(int unsigned d, int unsigned lim);
            int unsigned c;
            c = (TWICE_UNITY * d + scale) / (2 * scale);
            if (c >= lim) c = lim - 1;
            return c;
        endfunction

        function void configure(t_cfg_idx idx, logic [CFG_DATA_W-1:0] val);
            int unsigned sc;
            sc = val[SCALE_W-1:0];
            case (idx)
                CFG_SCALE: begin
                    if (sc >= 1 && sc <= MAX_SC) scale = sc;
                end
                CFG_WIDTH: begin
                    width    = fit_dim(val, MAX_W);
                    load_ptr = 0;
                end
                CFG_HEIGHT: begin
                    height   = fit_dim(val, MAX_H);
                    load_ptr = 0;
                end
                default: return;
            endcase
            col = 0;
            row = 0;
        endfunction

        function void take_item(t_action act, logic [PIX_W-1:0] pix);
            int unsigned   area, dw, dh, sx, sy;
            t_scaled_pixel p;
            if (act == ACT_LOAD) begin
                loads++;
                area = width * height;
                if (load_ptr >= area) load_ptr = 0;
                src_image[load_ptr] = pix;
                load_ptr++;
                if (load_ptr >= area) load_ptr = 0;
                return;
            end
            fetches++;
            dw = width * scale / UNITY_PCT;
            dh = height * scale / UNITY_PCT;
            if (dw == 0 || dh == 0) begin
                empty_fetches++;
                return;
            end
            if (col >= dw || row >= dh) begin
                col = 0;
                row = 0;
            end
            sx      = nearest_src(col, width);
            sy      = nearest_src(row, height);
            p.pixel = src_image[(sy * width + sx) % STORE_DEPTH];
            p.x     = COORD_W'(col);
            p.y     = COORD_W'(row);
            p.last  = (col == dw - 1) && (row == dh - 1);
            pending_pixels.push_back(p);
            col++;
            if (col >= dw) begin
                col = 0;
                row++;
                if (row >= dh) row = 0;
            end
        endfunction

        function void note_mismatch(string field, longint unsigned want, longint unsigned got);
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        endfunction

        function void check_pixel(logic [M_TDATA_W-1:0] data, logic last);
            t_scaled_pixel want, got;
            got.pixel = data[PIX_W-1:0];
            got.x     = data[PIX_W +: COORD_W];
            got.y     = data[PIX_W + COORD_W +: COORD_W];
            got.last  = last;
            if (pending_pixels.size() == 0) begin
                errors++;
                $display("%0t: unexpected item, expected none, actual pixel %h at (%0d,%0d)",
                         $time, got.pixel, got.x, got.y);
                return;
            end
            want = pending_pixels.pop_front();
            checked++;
            if (got.pixel !== want.pixel) note_mismatch("pixel_out", want.pixel, got.pixel);
            if (got.x !== want.x)         note_mismatch("dest_x", want.x, got.x);
            if (got.y !== want.y)         note_mismatch("dest_y", want.y, got.y);
            if (got.last !== want.last)   note_mismatch("last_pixel", want.last, got.last);
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata;   // [31:0] pixel_in
    logic                  s_axis_tuser;   // [0] action
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [M_TDATA_W-1:0]  m_axis_tdata;   // [31:0] pixel_out, [41:32] dest_x, [51:42] dest_y
    logic                  m_axis_tlast;   // last_pixel

    scaled_frame_board board = new();
    int                max_gap = 3;
    bit                hold_req = 1'b0;
    int                holds = 0;
    int                cfg_writes = 0;
    int unsigned       items_sent = 0;
    longint            cycle_count = 0;

    nearest_neighbor_image_scaler u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d pixels still expected",
                     cycle_count, board.pending_pixels.size());
            $display("testbench: FAIL");
            $finish;
        end
    end

    // called at a rising edge; returns at the edge where the item is accepted
    task automatic send_item(t_action act, logic [PIX_W-1:0] pix);
        int unsigned gap;
        gap = $urandom_range(0, max_gap);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pix;
        s_axis_tuser  <= act;
        do @(posedge i_clk); while (!s_axis_tready);
        board.take_item(act, pix);
        items_sent++;
    endtask

    task automatic load_pixels(int unsigned n);
        repeat (n) send_item(ACT_LOAD, $urandom);
    endtask

    task automatic fetch_pixels(int unsigned n);
        repeat (n) send_item(ACT_FETCH, $urandom);
    endtask

    // only with nothing in flight: drain, let the datapath settle, then write
    task automatic write_reg(t_cfg_idx idx, int unsigned val);
        s_axis_tvalid <= 1'b0;
        while (board.pending_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= CFG_DATA_W'(val);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        board.configure(idx, CFG_DATA_W'(val));
        cfg_writes++;
    endtask

    task automatic random_frame();
        int unsigned pick, sc, n;
        pick = $urandom_range(0, 7);
        if (pick != 0) begin
            if ($urandom_range(0, 3) == 0) load_pixels($urandom_range(1, 5));
            write_reg(CFG_WIDTH, $urandom_range(1, 16));
            write_reg(CFG_HEIGHT, $urandom_range(1, 8));
        end
        case ($urandom_range(0, 9))
            0:       sc = $urandom_range(0, 1) ? 0 : $urandom_range(MAX_SC + 1, DIM_LIMIT);
            1:       sc = MAX_SC;
            2:       sc = $urandom_range(1, 30);
            default: sc = $urandom_range(31, MAX_SC);
        endcase
        write_reg(CFG_SCALE, sc);
        if ($urandom_range(0, 5) == 0) write_reg(CFG_NONE, $urandom);
        if (pick != 0) load_pixels(board.width * board.height + $urandom_range(0, 3));
        n = $urandom_range(8, 48);
        repeat (n) begin
            if ($urandom_range(0, 3) == 0) send_item(ACT_LOAD, $urandom);
            else                           send_item(ACT_FETCH, $urandom);
        end
    endtask

    // output side: random stalls per item, one long hold-off on request
    initial begin
        int unsigned stall;
        m_axis_tready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = $urandom_range(0, max_gap);
            if (hold_req) begin
                stall    = HOLD_CYCLES;
                hold_req = 1'b0;
                holds++;
            end
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            board.check_pixel(m_axis_tdata, m_axis_tlast);
        end
    end

    initial begin
        int unsigned start_items;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= CFG_NONE;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= ACT_LOAD;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: small frame, wraps, ignored scale writes, empty frame, 200%
        send_item(ACT_LOAD, 32'h1234_5678);
        write_reg(CFG_WIDTH, 3);
        write_reg(CFG_HEIGHT, 2);
        write_reg(CFG_NONE, '1);
        send_item(ACT_LOAD, 32'h0000_0000);
        send_item(ACT_LOAD, 32'hFFFF_FFFF);
        send_item(ACT_LOAD, 32'hA5A5_A5A5);
        send_item(ACT_LOAD, 32'h5A5A_5A5A);
        send_item(ACT_LOAD, 32'h8000_0001);
        send_item(ACT_LOAD, 32'h7FFF_FFFE);
        send_item(ACT_LOAD, 32'hC3C3_3C3C);
        fetch_pixels(7);
        write_reg(CFG_SCALE, 0);
        fetch_pixels(1);
        write_reg(CFG_SCALE, MAX_SC + 1);
        write_reg(CFG_SCALE, SCALE_LIMIT);
        write_reg(CFG_SCALE, 10'h12C);      // upper bits dropped: 44%, empty frame
        fetch_pixels(2);
        write_reg(CFG_SCALE, MAX_SC);
        fetch_pixels(3);
        write_reg(CFG_NONE, 0);             // fetch position must carry on
        fetch_pixels(5);

        // size extremes; only the sampled pixels are loaded
        write_reg(CFG_WIDTH, 0);
        write_reg(CFG_HEIGHT, DIM_LIMIT);
        write_reg(CFG_SCALE, UNITY_PCT);
        load_pixels(4);
        fetch_pixels(4);
        write_reg(CFG_WIDTH, 16);
        write_reg(CFG_HEIGHT, 1);
        write_reg(CFG_SCALE, MAX_SC);
        load_pixels(16);
        hold_req = 1'b1;
        fetch_pixels(64);

        // smallest scale that still yields a frame, streamed with no gaps;
        // only the top-left pixel is sampled
        max_gap = 0;
        write_reg(CFG_WIDTH, UNITY_PCT);
        write_reg(CFG_HEIGHT, UNITY_PCT);
        write_reg(CFG_SCALE, 1);
        load_pixels(1);
        fetch_pixels(3);
        max_gap = 3;

        // fully loaded small image before frames that keep the size
        write_reg(CFG_WIDTH, 4);
        write_reg(CFG_HEIGHT, 4);
        load_pixels(16);

        start_items = items_sent;
        while (items_sent - start_items < RANDOM_ITEMS) random_frame();

        s_axis_tvalid <= 1'b0;
        while (board.pending_pixels.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("covered %0d loads and %0d fetches (%0d on empty frames), %0d register writes",
                 board.loads, board.fetches, board.empty_fetches, cfg_writes);
        $display("%0d scaled pixels checked, %0d errors, %0d long output hold-offs",
                 board.checked, board.errors, holds);
        if (board.errors == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
